// ===== design/idr_pkg.sv =====
package idr_pkg;

  // Field widths of the two channels.
  localparam int OP_W     = 2;
  localparam int OFFSET_W = 16;
  localparam int DATA_W   = 32;
  localparam int IRQ_W    = 8;
  localparam int PRIO_W   = 8;

  // Register map, byte offsets within the frame.
  localparam logic [OFFSET_W-1:0] SET_LO = 16'h0100;
  localparam logic [OFFSET_W-1:0] SET_HI = 16'h017C;
  localparam logic [OFFSET_W-1:0] CLR_LO = 16'h0180;
  localparam logic [OFFSET_W-1:0] CLR_HI = 16'h01FC;
  localparam logic [OFFSET_W-1:0] PRI_LO = 16'h0400;
  localparam logic [OFFSET_W-1:0] PRI_HI = 16'h07F8;

  localparam logic [PRIO_W-1:0] DEF_PRIO = 8'hA0;
  localparam logic [DATA_W-1:0] SGI_MASK = 32'h0000FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_QUERY = 2'd2
  } idr_op_t;

  // What the second stage has to build for the result.
  typedef enum logic [1:0] {
    KIND_ZERO   = 2'd0,
    KIND_ENABLE = 2'd1,
    KIND_PRIO   = 2'd2,
    KIND_QUERY  = 2'd3
  } idr_kind_t;

  // Value an enable word holds after reset: the SGI bits are on in word 0 only.
  function automatic logic [DATA_W-1:0] ew_reset(input logic word_zero);
    ew_reset = word_zero ? SGI_MASK : '0;
  endfunction

endpackage

// ===== design/idr_in_if.sv =====
interface idr_in_if import idr_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [OFFSET_W-1:0] offset;
  logic [DATA_W-1:0]   write_data;
  logic [IRQ_W-1:0]    irq;

  modport source (output valid, output operation, output offset, output write_data,
                  output irq, input ready);
  modport sink   (input valid, input operation, input offset, input write_data,
                  input irq, output ready);
endinterface

// ===== design/idr_out_if.sv =====
interface idr_out_if import idr_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic [PRIO_W-1:0] irq_prio;
  logic              irq_enabled;

  modport source (output valid, output read_data, output irq_prio,
                  output irq_enabled, input ready);
  modport sink   (input valid, input read_data, input irq_prio,
                  input irq_enabled, output ready);
endinterface

// ===== design/idr_prio_bank.sv =====
// One byte lane of the priority store. Port A serves register accesses and
// shares its address with the write port; port B serves delivery queries.
module idr_prio_bank import idr_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [PRIO_W-1:0] wr_data,
  input  logic              rd_en_a,
  input  logic [AW-1:0]     addr_a,
  output logic [PRIO_W-1:0] rd_data_a,
  input  logic              rd_en_b,
  input  logic [AW-1:0]     addr_b,
  output logic [PRIO_W-1:0] rd_data_b
);

  logic [PRIO_W-1:0] mem [DEPTH];
  logic [PRIO_W-1:0] data_a_r;
  logic [PRIO_W-1:0] data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_a] <= wr_data;
    end
    if (rd_en_a) begin
      data_a_r <= mem[addr_a];
    end
    if (rd_en_b) begin
      data_b_r <= mem[addr_b];
    end
  end

  assign rd_data_a = data_a_r;
  assign rd_data_b = data_b_r;

endmodule

// ===== design/interrupt_distributor_registers.sv =====
// Channel   Port     Direction  Payload
// --------  -------  ---------  ----------------------------------------------
// request   in_ch    sink       operation, offset, write_data, irq
// result    out_ch   source     read_data, irq_prio, irq_enabled
//
// One item is taken every cycle while the result side does not stall. Its result
// is captured first by the registered reads of the priority banks and the enable
// words, then by the result register, from which it leaves on the result channel.
// Reset is synchronous; it clears the valid bits of both stores, and an entry
// not yet written reads as its reset value.
// When the result side stalls, the read stage keeps one more item and the
// request side sees ready low only while both stages are full.
module interrupt_distributor_registers import idr_pkg::*; #(
  parameter int NUM_IRQS         = 256,
  parameter int NUM_ENABLE_WORDS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  idr_in_if.sink     in_ch,
  idr_out_if.source  out_ch
);

  localparam int IRQ_AW     = $clog2(NUM_IRQS);
  localparam int BANK_DEPTH = (NUM_IRQS + 3) / 4;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int EW_AW      = (NUM_ENABLE_WORDS > 1) ? $clog2(NUM_ENABLE_WORDS) : 1;

  localparam logic [10:0] NUM_IRQS_L = 11'(NUM_IRQS);
  localparam logic [8:0]  NUM_IRQS_Q = 9'(NUM_IRQS);
  localparam logic [5:0]  NUM_EW_L   = 6'(NUM_ENABLE_WORDS);
  localparam logic [3:0]  NUM_EW_Q   = 4'(NUM_ENABLE_WORDS);

  // Control carried from the read stage to the result stage.
  typedef struct packed {
    idr_kind_t  kind;
    logic       w_zero;
    logic       en_a_vld;
    logic [1:0] rot;
    logic [3:0] lane_in;
    logic [3:0] lane_vld;
    logic       q_oor;
    logic       q_vld;
    logic       qw_in;
    logic       qw_zero;
    logic       qw_vld;
    logic [4:0] q_bit;
    logic [1:0] q_bank;
  } s1_ctrl_t;

  // Handshake and pipeline occupancy.
  logic      accept;
  logic      s1_adv;
  logic      s1_valid_r, s1_valid_nxt;
  logic      out_valid_r, out_valid_nxt;
  s1_ctrl_t  s1_r, s1_nxt;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept      = in_ch.valid && in_ch.ready;

  // Decode of the request.
  idr_op_t        op;
  logic           is_write, is_read, is_query;
  logic           in_set, in_clr, in_pri;
  logic [4:0]     ew_sel;
  logic           ew_in;
  logic [EW_AW-1:0] ew_idx;
  logic [9:0]     pri_base;

  assign op       = idr_op_t'(in_ch.operation);
  assign is_write = (op == OP_WRITE);
  assign is_read  = (op == OP_READ);
  assign is_query = (op == OP_QUERY);
  assign in_set   = (in_ch.offset >= SET_LO) && (in_ch.offset <= SET_HI);
  assign in_clr   = (in_ch.offset >= CLR_LO) && (in_ch.offset <= CLR_HI);
  assign in_pri   = (in_ch.offset >= PRI_LO) && (in_ch.offset <= PRI_HI);
  // Both enable ranges start on a 128-byte boundary, so the word number is
  // simply bits 6:2 of the offset; the priority range starts on a 1 KiB
  // boundary, so the first interrupt is the low ten bits.
  assign ew_sel   = in_ch.offset[6:2];
  assign ew_in    = ({1'b0, ew_sel} < NUM_EW_L);
  assign ew_idx   = ew_sel[EW_AW-1:0];
  assign pri_base = in_ch.offset[9:0];

  // Priority lanes. Byte b of a window starting at interrupt n lands in bank
  // (n + b) mod 4, so an unaligned window touches each bank exactly once.
  logic [1:0]        lane_ofs  [4];
  logic [10:0]       lane_addr [4];
  logic [3:0]        lane_in;
  logic [3:0]        lane_vld;
  logic [3:0]        pri_wr;
  logic [3:0]        pri_rd;
  logic [PRIO_W-1:0] lane_data [4];
  logic [BANK_AW-1:0] lane_idx [4];
  logic [PRIO_W-1:0] bank_a    [4];
  logic [PRIO_W-1:0] bank_b    [4];
  logic [NUM_IRQS-1:0] prio_vld_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lane_ofs[k]  = 2'(k) - pri_base[1:0];
      lane_addr[k] = {1'b0, pri_base} + {9'd0, lane_ofs[k]};
      lane_in[k]   = lane_addr[k] < NUM_IRQS_L;
      lane_idx[k]  = lane_addr[k][2 +: BANK_AW];
      lane_data[k] = in_ch.write_data[{lane_ofs[k], 3'b000} +: PRIO_W];
      lane_vld[k]  = lane_in[k] ? prio_vld_r[lane_addr[k][IRQ_AW-1:0]] : 1'b0;
      pri_wr[k]    = accept && is_write && in_pri && lane_in[k];
      pri_rd[k]    = accept && is_read && in_pri && lane_in[k];
    end
  end

  // Delivery query lookups.
  logic               q_in;
  logic [BANK_AW-1:0] q_idx;
  logic               q_vld;
  logic [2:0]         qw_sel;
  logic               qw_in;
  logic [EW_AW-1:0]   qw_idx;

  assign q_in   = ({1'b0, in_ch.irq} < NUM_IRQS_Q);
  assign q_idx  = in_ch.irq[2 +: BANK_AW];
  assign q_vld  = q_in ? prio_vld_r[in_ch.irq[IRQ_AW-1:0]] : 1'b0;
  assign qw_sel = in_ch.irq[7:5];
  assign qw_in  = q_in && ({1'b0, qw_sel} < NUM_EW_Q);
  assign qw_idx = qw_sel[EW_AW-1:0];

  for (genvar g = 0; g < 4; g++) begin : g_bank
    idr_prio_bank #(
      .DEPTH (BANK_DEPTH),
      .AW    (BANK_AW)
    ) u_bank (
      .clk       (clk),
      .wr_en     (pri_wr[g]),
      .wr_data   (lane_data[g]),
      .rd_en_a   (pri_rd[g]),
      .addr_a    (lane_idx[g]),
      .rd_data_a (bank_a[g]),
      .rd_en_b   (accept && is_query && q_in),
      .addr_b    (q_idx),
      .rd_data_b (bank_b[g])
    );
  end

  // Enable-word memory with per-bit write enables. A word that was never
  // written is written in full, starting from its reset value, so the
  // merge never needs a read of the old contents.
  logic [DATA_W-1:0] en_mem [NUM_ENABLE_WORDS];
  logic [NUM_ENABLE_WORDS-1:0] en_vld_r;
  logic [DATA_W-1:0] en_a_data_r;
  logic [DATA_W-1:0] en_b_data_r;
  logic              en_wr;
  logic              en_a_vld;
  logic [DATA_W-1:0] en_rst_a;
  logic [DATA_W-1:0] en_dmask;
  logic [DATA_W-1:0] en_wbits;
  logic [DATA_W-1:0] en_wmask;
  logic              en_b_rd;

  assign en_wr    = accept && is_write && (in_set || in_clr) && ew_in;
  assign en_a_vld = ew_in ? en_vld_r[ew_idx] : 1'b0;
  assign en_rst_a = ew_reset(ew_sel == 5'd0);
  // A clear of word 0 never touches the SGI bits; they stay enabled.
  assign en_dmask = in_clr ? (in_ch.write_data & ~en_rst_a) : in_ch.write_data;
  assign en_wbits = in_clr ? (en_rst_a & ~en_dmask) : (en_rst_a | en_dmask);
  assign en_wmask = en_a_vld ? en_dmask : '1;
  assign en_b_rd  = accept && is_query && qw_in;

  always_ff @(posedge clk) begin
    if (en_wr) begin
      for (int i = 0; i < DATA_W; i++) begin
        if (en_wmask[i]) begin
          en_mem[ew_idx][i] <= en_wbits[i];
        end
      end
    end
    if (accept && is_read && (in_set || in_clr) && ew_in) begin
      en_a_data_r <= en_mem[ew_idx];
    end
    if (en_b_rd) begin
      en_b_data_r <= en_mem[qw_idx];
    end
  end

  // Valid bits of both stores.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_vld_r   <= '0;
      prio_vld_r <= '0;
    end else begin
      if (en_wr) begin
        en_vld_r[ew_idx] <= 1'b1;
      end
      for (int k = 0; k < 4; k++) begin
        if (pri_wr[k]) begin
          prio_vld_r[lane_addr[k][IRQ_AW-1:0]] <= 1'b1;
        end
      end
    end
  end

  // Control for the result stage, captured along with the memory reads.
  always_comb begin
    s1_nxt          = s1_r;
    s1_nxt.w_zero   = (ew_sel == 5'd0);
    s1_nxt.en_a_vld = en_a_vld;
    s1_nxt.rot      = pri_base[1:0];
    s1_nxt.lane_in  = lane_in;
    s1_nxt.lane_vld = lane_vld;
    s1_nxt.q_oor    = !q_in;
    s1_nxt.q_vld    = q_vld;
    s1_nxt.qw_in    = qw_in;
    s1_nxt.qw_zero  = (qw_sel == 3'd0);
    s1_nxt.qw_vld   = qw_in ? en_vld_r[qw_idx] : 1'b0;
    s1_nxt.q_bit    = in_ch.irq[4:0];
    s1_nxt.q_bank   = in_ch.irq[1:0];
    priority if (is_read && (in_set || in_clr) && ew_in) begin
      s1_nxt.kind = KIND_ENABLE;
    end else if (is_read && in_pri) begin
      s1_nxt.kind = KIND_PRIO;
    end else if (is_query) begin
      s1_nxt.kind = KIND_QUERY;
    end else begin
      s1_nxt.kind = KIND_ZERO;
    end
  end

  assign s1_valid_nxt  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The control word starts out as a zero result so that the result
  // formatting never sees an unknown kind.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  // Result formatting from the registered reads.
  logic [DATA_W-1:0] rd_r, rd_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic              en_r, en_nxt;

  always_comb begin
    logic [1:0]        k;
    logic [DATA_W-1:0] qword;
    rd_nxt   = '0;
    prio_nxt = '0;
    en_nxt   = 1'b0;
    k        = '0;
    qword    = s1_r.qw_vld ? en_b_data_r : ew_reset(s1_r.qw_zero);
    unique case (s1_r.kind)
      KIND_ZERO: begin
        rd_nxt = '0;
      end
      KIND_ENABLE: begin
        rd_nxt = s1_r.en_a_vld ? en_a_data_r : ew_reset(s1_r.w_zero);
      end
      KIND_PRIO: begin
        for (int b = 0; b < 4; b++) begin
          k = s1_r.rot + 2'(b);
          if (s1_r.lane_in[k]) begin
            rd_nxt[b*PRIO_W +: PRIO_W] = s1_r.lane_vld[k] ? bank_a[k] : DEF_PRIO;
          end
        end
      end
      KIND_QUERY: begin
        if (s1_r.q_oor) begin
          prio_nxt = DEF_PRIO;
          en_nxt   = 1'b1;
        end else begin
          prio_nxt = s1_r.q_vld ? bank_b[s1_r.q_bank] : DEF_PRIO;
          en_nxt   = s1_r.qw_in ? qword[s1_r.q_bit] : 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rd_r   <= rd_nxt;
      prio_r <= prio_nxt;
      en_r   <= en_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = rd_r;
  assign out_ch.irq_prio    = prio_r;
  assign out_ch.irq_enabled = en_r;

endmodule
